[rtl/core/tsp_pkg.sv]
// Shared types and constants for the timed slot pool.
package tsp_pkg;

   localparam int SLOTS_DEFAULT = 64;
   localparam int SLOTS_MAX     = 64;

   localparam int SLOT_W  = 6;
   localparam int COUNT_W = 16;
   localparam int PARAM_W = 8;

   typedef enum logic [1:0] {
      OP_CREATE  = 2'd0,
      OP_FRAME   = 2'd1,
      OP_DESTROY = 2'd2,
      OP_QUERY   = 2'd3
   } op_type;

   // One slot of the pool as it travels along the ring.
   typedef struct packed {
      logic               valid;
      logic [COUNT_W-1:0] count;
      logic [COUNT_W-1:0] limit;
   } entry_type;

endpackage

[rtl/core/tsp_cell.sv]
// One ring cell: holds a single slot and loads its neighbor's slot on a shift.
module tsp_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  tsp_pkg::entry_type entry_in,
   output tsp_pkg::entry_type entry_out
);

   logic                        valid_ff;
   logic [tsp_pkg::COUNT_W-1:0] count_ff;
   logic [tsp_pkg::COUNT_W-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else if (shift) begin
         valid_ff <= entry_in.valid;
         count_ff <= entry_in.count;
      end
   end

   // limit is meaningful only once a create has written it
   always_ff @(posedge clock) begin
      if (shift) begin
         limit_ff <= entry_in.limit;
      end
   end

   assign entry_out.valid = valid_ff;
   assign entry_out.count = count_ff;
   assign entry_out.limit = limit_ff;

endmodule

[rtl/core/tsp_chain.sv]
// Ring of slot cells: cell 0 is the head, the processed head re-enters at the tail.
module tsp_chain #(
   parameter int SLOTS = tsp_pkg::SLOTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  tsp_pkg::entry_type tail_in,
   output tsp_pkg::entry_type head_out
);

   tsp_pkg::entry_type cell_q [SLOTS];

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      tsp_pkg::entry_type cell_d;

      if (i == SLOTS - 1) begin : g_tail
         assign cell_d = tail_in;
      end else begin : g_body
         assign cell_d = cell_q[i+1];
      end

      tsp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (shift),
         .entry_in  (cell_d),
         .entry_out (cell_q[i])
      );
   end

   assign head_out = cell_q[0];

endmodule

[rtl/core/timed_slot_pool.sv]
// Top level of the timed slot pool: request decode, head processor and result register.
// Sequence: an accepted request walks one ring rotation of SLOTS steps, then a finish
//   state emits its final result (a destroy emits none); rsp_tready stalls can hold either.
// Requests do not overlap: req_tready is high only when idle, so every operation takes a
//   full rotation of the slot ring through the single head processor before the next.
// A frame tick delivers its drawn slots one per step at most, the last in the finish state.
// Reset: synchronous; clears all valid bits and counters at once, no clearing pass.
module timed_slot_pool #(
   parameter int SLOTS = tsp_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // pattern_count[7:0], frames_per_pattern[15:8],
                                   // slot[21:16], zero[23:22]
   input  logic [1:0]  req_tuser,  // operation[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // slot_index[5:0], elapsed[21:6], active[22], zero[23]
   output logic        rsp_tlast   // last result caused by the request
);

   localparam int IdxW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SlotW   = tsp_pkg::SLOT_W;
   localparam int CountW  = tsp_pkg::COUNT_W;
   localparam int ParamW  = tsp_pkg::PARAM_W;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   // control state
   state_type         state_ff, state_in;
   logic [IdxW-1:0]   idx_ff, idx_in;
   logic              found_ff, found_in;     // create succeeded / queried slot valid
   logic              pend_valid_ff, pend_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // request payload, held for the whole rotation
   tsp_pkg::op_type   op_ff, op_in;
   logic [CountW-1:0] limit_ff, limit_in;
   logic [SlotW-1:0]  slot_ff, slot_in;
   logic [SlotW-1:0]  found_idx_ff, found_idx_in;

   // drawn slot held back until we know whether it is the last one
   logic [SlotW-1:0]  pend_idx_ff, pend_idx_in;
   logic [CountW-1:0] pend_count_ff, pend_count_in;

   // result register
   logic [SlotW-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [CountW-1:0] rsp_elapsed_ff, rsp_elapsed_in;
   logic              rsp_active_ff, rsp_active_in;
   logic              rsp_last_ff, rsp_last_in;

   // ring interface
   tsp_pkg::entry_type head;
   tsp_pkg::entry_type tail;
   logic               step;

   logic              req_fire;
   logic              out_free;
   logic              emit;
   logic [SlotW-1:0]  head_idx;
   logic              at_end;

   tsp_chain #(
      .SLOTS (SLOTS)
   ) u_chain (
      .clock    (clock),
      .reset    (reset),
      .shift    (step),
      .tail_in  (tail),
      .head_out (head)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign head_idx   = SlotW'(idx_ff);
   assign at_end     = (idx_ff == IdxW'(SLOTS - 1));

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      pend_valid_in  = pend_valid_ff;
      pend_idx_in    = pend_idx_ff;
      pend_count_in  = pend_count_ff;
      op_in          = op_ff;
      limit_in       = limit_ff;
      slot_in        = slot_ff;
      tail           = head;
      step           = 1'b0;
      emit           = 1'b0;
      rsp_idx_in     = rsp_idx_ff;
      rsp_elapsed_in = rsp_elapsed_ff;
      rsp_active_in  = rsp_active_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // latch the request; the lifetime product is formed here once
               op_in         = tsp_pkg::op_type'(req_tuser);
               limit_in      = CountW'(req_tdata[ParamW-1:0])
                               * CountW'(req_tdata[2*ParamW-1:ParamW]);
               slot_in       = req_tdata[2*ParamW+SlotW-1:2*ParamW];
               found_in      = 1'b0;
               found_idx_in  = '0;
               pend_valid_in = 1'b0;
               idx_in        = '0;
               state_in      = ST_SCAN;
            end
         end

         ST_SCAN: begin
            step = 1'b1;
            unique case (op_ff)
               tsp_pkg::OP_CREATE: begin
                  // claim the first free slot seen in the rotation
                  if (!head.valid && !found_ff) begin
                     tail.valid   = 1'b1;
                     tail.count   = '0;
                     tail.limit   = limit_ff;
                     found_in     = 1'b1;
                     found_idx_in = head_idx;
                  end
               end
               tsp_pkg::OP_FRAME: begin
                  if (head.valid) begin
                     if (head.count >= head.limit) begin
                        // retire: lifetime used up
                        tail.valid = 1'b0;
                        tail.count = '0;
                     end else begin
                        // draw: push the held-back slot out, hold this one
                        if (pend_valid_ff) begin
                           step = out_free;
                           emit = out_free;
                           rsp_idx_in     = pend_idx_ff;
                           rsp_elapsed_in = pend_count_ff;
                           rsp_active_in  = 1'b1;
                           rsp_last_in    = 1'b0;
                        end
                        pend_valid_in = 1'b1;
                        pend_idx_in   = head_idx;
                        pend_count_in = head.count;
                        if (head.count != {CountW{1'b1}}) begin
                           tail.count = head.count + CountW'(1);
                        end
                     end
                  end
               end
               tsp_pkg::OP_DESTROY: begin
                  if (head_idx == slot_ff) begin
                     tail.valid = 1'b0;
                  end
               end
               tsp_pkg::OP_QUERY: begin
                  if (head_idx == slot_ff) begin
                     found_in = head.valid;
                  end
               end
               default: begin
               end
            endcase

            if (!step) begin
               // stalled on the result register: hold everything in place
               pend_valid_in = pend_valid_ff;
               pend_idx_in   = pend_idx_ff;
               pend_count_in = pend_count_ff;
            end else if (at_end) begin
               idx_in   = '0;
               state_in = ST_FINISH;
            end else begin
               idx_in = idx_ff + IdxW'(1);
            end
         end

         ST_FINISH: begin
            if (op_ff == tsp_pkg::OP_DESTROY) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               emit        = 1'b1;
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
               unique case (op_ff)
                  tsp_pkg::OP_CREATE: begin
                     rsp_idx_in     = found_ff ? found_idx_ff : '0;
                     rsp_elapsed_in = '0;
                     rsp_active_in  = found_ff;
                  end
                  tsp_pkg::OP_FRAME: begin
                     rsp_idx_in     = pend_valid_ff ? pend_idx_ff : '0;
                     rsp_elapsed_in = pend_valid_ff ? pend_count_ff : '0;
                     rsp_active_in  = pend_valid_ff;
                     pend_valid_in  = 1'b0;
                  end
                  default: begin
                     // query
                     rsp_idx_in     = slot_ff;
                     rsp_elapsed_in = '0;
                     rsp_active_in  = found_ff;
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register: load on emit, drop when taken
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         found_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         found_ff      <= found_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      limit_ff      <= limit_in;
      slot_ff       <= slot_in;
      found_idx_ff  <= found_idx_in;
      pend_idx_ff   <= pend_idx_in;
      pend_count_ff <= pend_count_in;
      if (emit) begin
         rsp_idx_ff     <= rsp_idx_in;
         rsp_elapsed_ff <= rsp_elapsed_in;
         rsp_active_ff  <= rsp_active_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_active_ff, rsp_elapsed_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;

   // ring position is back at slot 0 whenever no request is in flight
   a_idle_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (idx_ff == '0))
      else $error("ring not aligned at idle");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   // only frame ticks hold a drawn slot back
   a_pend_frame: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (op_ff == tsp_pkg::OP_FRAME && state_ff != ST_IDLE))
      else $error("held-back slot outside a frame tick");

   // results emitted mid-rotation are non-final frame draws
   a_scan_emit: assert property (@(posedge clock) disable iff (reset)
      (emit && state_ff == ST_SCAN) |-> (op_ff == tsp_pkg::OP_FRAME && !rsp_last_in))
      else $error("unexpected result during rotation");

   // a stalled rotation keeps its position
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && !step) |=> (state_ff == ST_SCAN && $stable(idx_ff)))
      else $error("ring moved while stalled");

endmodule

[tb/timed_slot_pool_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the timed slot pool: create, frame tick, destroy and query requests.
module timed_slot_pool_tb;

   localparam int POOL_SLOTS     = tsp_pkg::SLOTS_DEFAULT;
   localparam int SLOT_W         = tsp_pkg::SLOT_W;
   localparam int COUNT_W        = tsp_pkg::COUNT_W;
   localparam int PARAM_W        = tsp_pkg::PARAM_W;
   // Allowance for one full ring rotation plus the accept and finish states of a request.
   localparam int REQUEST_CYCLES = POOL_SLOTS + 2;
   localparam int ITEM_TARGET    = 230;
   localparam int FILL_AT        = 120;
   localparam int SWEEP_DESTROYS = 40;
   localparam int HOLD_AT_RESULT = 30;
   localparam int HOLD_CYCLES    = 400;
   localparam int IDLE_LIMIT     = 3000;

   // One result as it leaves the block, compared field by field.
   typedef struct packed {
      logic [SLOT_W-1:0]  slot_index;
      logic [COUNT_W-1:0] elapsed;
      logic               active;
      logic               last;
   } pool_result_type;

   // Shadow copy of the pool plus the queue of results still owed by the block.
   class slot_pool_scoreboard;
      bit                 slot_live [POOL_SLOTS];
      bit [COUNT_W-1:0]   frames_shown [POOL_SLOTS];
      bit [COUNT_W-1:0]   lifetime [POOL_SLOTS];
      pool_result_type    owed_results [$];
      int errors, checked;
      int creates, refused, frames, destroys, queries, drawn, retired, empty_frames;

      function new();
         for (int i = 0; i < POOL_SLOTS; i++) begin
            slot_live[i]    = 1'b0;
            frames_shown[i] = '0;
            lifetime[i]     = '0;
         end
         errors = 0; checked = 0; creates = 0; refused = 0; frames = 0;
         destroys = 0; queries = 0; drawn = 0; retired = 0; empty_frames = 0;
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      function int live_count();
         int n;
         n = 0;
         for (int i = 0; i < POOL_SLOTS; i++) n += slot_live[i];
         return n;
      endfunction

      function void owe(int idx, bit [COUNT_W-1:0] el, bit act, bit last);
         pool_result_type r;
         r.slot_index = idx[SLOT_W-1:0];
         r.elapsed    = el;
         r.active     = act;
         r.last       = last;
         owed_results.push_back(r);
      endfunction

      // Advance the shadow pool by one accepted request and queue what it owes.
      function void note_request(tsp_pkg::op_type op, bit [PARAM_W-1:0] patterns,
                                 bit [PARAM_W-1:0] per_pattern, bit [SLOT_W-1:0] slot);
         int free_idx, final_live, n;
         case (op)
            tsp_pkg::OP_CREATE: begin
               creates++;
               free_idx = -1;
               for (int i = POOL_SLOTS - 1; i >= 0; i--)
                  if (!slot_live[i]) free_idx = i;
               if (free_idx < 0) begin
                  refused++;
                  owe(0, '0, 1'b0, 1'b1);
               end else begin
                  slot_live[free_idx]    = 1'b1;
                  frames_shown[free_idx] = '0;
                  lifetime[free_idx]     = COUNT_W'(patterns) * COUNT_W'(per_pattern);
                  owe(free_idx, '0, 1'b1, 1'b1);
               end
            end
            tsp_pkg::OP_FRAME: begin
               frames++;
               // Retire expired slots before anything is drawn.
               for (int i = 0; i < POOL_SLOTS; i++)
                  if (slot_live[i] && frames_shown[i] >= lifetime[i]) begin
                     slot_live[i]    = 1'b0;
                     frames_shown[i] = '0;
                     retired++;
                  end
               final_live = -1;
               for (int i = 0; i < POOL_SLOTS; i++)
                  if (slot_live[i]) final_live = i;
               n = 0;
               for (int i = 0; i < POOL_SLOTS; i++)
                  if (slot_live[i]) begin
                     owe(i, frames_shown[i], 1'b1, i == final_live);
                     n++;
                     if (frames_shown[i] != '1) frames_shown[i]++;
                  end
               drawn += n;
               if (n == 0) begin
                  empty_frames++;
                  owe(0, '0, 1'b0, 1'b1);
               end
            end
            tsp_pkg::OP_DESTROY: begin
               destroys++;
               if (slot < POOL_SLOTS) slot_live[slot] = 1'b0;
            end
            default: begin
               queries++;
               owe(int'(slot), '0, (slot < POOL_SLOTS) && slot_live[slot], 1'b1);
            end
         endcase
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] result %0d: %s", $realtime, checked, msg);
         errors++;
      endtask

      task check_result(pool_result_type got);
         pool_result_type want;
         checked++;
         if (owed_results.size() == 0) begin
            report_mismatch($sformatf(
               "no result owed, got slot_index %0d elapsed %0d active %0b last %0b",
               got.slot_index, got.elapsed, got.active, got.last));
         end else begin
            want = owed_results.pop_front();
            if (got.slot_index !== want.slot_index)
               report_mismatch($sformatf("slot_index %0d, want %0d",
                                         got.slot_index, want.slot_index));
            if (got.elapsed !== want.elapsed)
               report_mismatch($sformatf("elapsed %0d, want %0d", got.elapsed, want.elapsed));
            if (got.active !== want.active)
               report_mismatch($sformatf("active %0b, want %0b", got.active, want.active));
            if (got.last !== want.last)
               report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
         end
      endtask

      task check_drained();
         if (owed_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", owed_results.size()));
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // pattern_count[7:0], frames_per_pattern[15:8],
                                   // slot[21:16], zero[23:22]
   logic [1:0]  req_tuser  = '0;   // operation[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // slot_index[5:0], elapsed[21:6], active[22], zero[23]
   logic        rsp_tlast;

   slot_pool_scoreboard board = new();
   int requests_sent = 0;
   int idle_cycles   = 0;

   timed_slot_pool #(.SLOTS(POOL_SLOTS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Offer one request after a random gap and hold it until the block takes it.
   // Return on the acceptance edge with tvalid still high, so a back-to-back
   // request never lowers and raises it within one time step.
   task send_request(tsp_pkg::op_type op, logic [PARAM_W-1:0] patterns,
                     logic [PARAM_W-1:0] per_pattern, logic [SLOT_W-1:0] slot);
      int gap;
      // Leave every third stretch of 40 requests without gaps.
      gap = ((requests_sent / 40) % 3 == 2) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, slot, per_pattern, patterns};
      do @(posedge clock); while (!req_tready);
      board.note_request(op, patterns, per_pattern, slot);
      requests_sent++;
   endtask

   // Drop tvalid, wait out every owed result, then let a trailing destroy finish its rotation.
   task drain_pool_requests();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (REQUEST_CYCLES + 4) @(posedge clock);
   endtask

   // Request side: a short directed pass, then random traffic with one fill-up phase.
   initial begin
      int                 pick, free_slots;
      bit                 filled;
      logic [PARAM_W-1:0] patterns, per_pattern;
      logic [SLOT_W-1:0]  slot;
      tsp_pkg::op_type    op;

      filled = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty pool: query reads invalid, frame tick reports nothing drawn.
      send_request(tsp_pkg::OP_QUERY,   8'd0,   8'd0,   6'd0);
      send_request(tsp_pkg::OP_FRAME,   8'd0,   8'd0,   6'd0);
      // Zero lifetime: the slot retires at the next tick without being drawn.
      send_request(tsp_pkg::OP_CREATE,  8'd0,   8'd0,   6'd0);
      send_request(tsp_pkg::OP_FRAME,   8'd0,   8'd0,   6'd0);
      // Largest lifetime, short lifetime and zero lifetimes from either factor.
      send_request(tsp_pkg::OP_CREATE,  8'd255, 8'd255, 6'd63);
      send_request(tsp_pkg::OP_CREATE,  8'd1,   8'd2,   6'd0);
      send_request(tsp_pkg::OP_CREATE,  8'd255, 8'd0,   6'd0);
      send_request(tsp_pkg::OP_CREATE,  8'd0,   8'd255, 6'd0);
      send_request(tsp_pkg::OP_CREATE,  8'd3,   8'd1,   6'd0);
      send_request(tsp_pkg::OP_QUERY,   8'd0,   8'd0,   6'd1);
      send_request(tsp_pkg::OP_QUERY,   8'd255, 8'd255, 6'd63);
      // Ticks draw the survivors and retire slots as their lifetimes run out.
      send_request(tsp_pkg::OP_FRAME,   8'd0,   8'd0,   6'd0);
      send_request(tsp_pkg::OP_FRAME,   8'd0,   8'd0,   6'd0);
      send_request(tsp_pkg::OP_FRAME,   8'd0,   8'd0,   6'd0);
      send_request(tsp_pkg::OP_DESTROY, 8'd0,   8'd0,   6'd0);
      send_request(tsp_pkg::OP_QUERY,   8'd0,   8'd0,   6'd0);
      // Destroy of a slot that is not live changes nothing.
      send_request(tsp_pkg::OP_DESTROY, 8'd0,   8'd0,   6'd63);
      send_request(tsp_pkg::OP_FRAME,   8'd0,   8'd0,   6'd0);
      send_request(tsp_pkg::OP_FRAME,   8'd0,   8'd0,   6'd0);
      send_request(tsp_pkg::OP_CREATE,  8'hAA,  8'h55,  6'h2A);
      send_request(tsp_pkg::OP_QUERY,   8'h55,  8'hAA,  6'h15);
      send_request(tsp_pkg::OP_DESTROY, 8'hFF,  8'hFF,  6'd0);

      while (requests_sent < ITEM_TARGET) begin
         if (!filled && requests_sent >= FILL_AT) begin
            filled = 1'b1;
            // Fill every free slot with a long-lived entry, then overrun the full pool.
            free_slots = POOL_SLOTS - board.live_count();
            repeat (free_slots + 2)
               send_request(tsp_pkg::OP_CREATE, 8'($urandom_range(128, 255)),
                            8'($urandom_range(128, 255)), 6'($urandom_range(0, 63)));
            send_request(tsp_pkg::OP_FRAME, 8'($urandom), 8'($urandom), 6'($urandom));
            send_request(tsp_pkg::OP_QUERY, 8'($urandom), 8'($urandom),
                         6'($urandom_range(0, 63)));
            // Thin the pool out again with a sweep of destroys.
            repeat (SWEEP_DESTROYS)
               send_request(tsp_pkg::OP_DESTROY, 8'($urandom), 8'($urandom),
                            6'($urandom_range(0, 63)));
            drain_pool_requests();
         end
         pick        = $urandom_range(0, 99);
         patterns    = 8'($urandom);
         per_pattern = 8'($urandom);
         slot        = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                   : 6'($urandom_range(0, 15));
         if (pick < 35) begin
            op = tsp_pkg::OP_CREATE;
            // Keep most lifetimes short so slots age out and get reused.
            if ($urandom_range(0, 3) != 0) begin
               patterns    = 8'($urandom_range(0, 4));
               per_pattern = 8'($urandom_range(0, 4));
            end
         end else if (pick < 65) begin
            op = tsp_pkg::OP_FRAME;
         end else if (pick < 80) begin
            op = tsp_pkg::OP_DESTROY;
         end else begin
            op = tsp_pkg::OP_QUERY;
         end
         send_request(op, patterns, per_pattern, slot);
      end

      drain_pool_requests();
      board.check_drained();
      $display("Sent %0d requests: %0d creates (%0d refused), %0d frame ticks, %0d destroys, %0d queries",
               requests_sent, board.creates, board.refused, board.frames,
               board.destroys, board.queries);
      $display("Checked %0d results: %0d slots drawn, %0d retired, %0d empty frames, %0d mismatches",
               board.checked, board.drawn, board.retired, board.empty_frames, board.errors);
      if (board.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Result side: random back-pressure, one long hold-off to fill the block up.
   initial begin
      int              gap, received;
      pool_result_type got;

      received = 0;
      wait (!reset);
      @(posedge clock);
      forever begin
         // Run every fourth stretch of 100 results with tready held high.
         gap = ((received / 100) % 4 == 3) ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.slot_index = rsp_tdata[5:0];
         got.elapsed    = rsp_tdata[21:6];
         got.active     = rsp_tdata[22];
         got.last       = rsp_tlast;
         board.check_result(got);
         received++;
         if (received == HOLD_AT_RESULT) begin
            // Stall the result channel long enough that request acceptance backs up.
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

[timed_slot_pool.f]
rtl/core/tsp_pkg.sv
rtl/core/tsp_cell.sv
rtl/core/tsp_chain.sv
rtl/core/timed_slot_pool.sv
tb/timed_slot_pool_tb.sv
